### hdl/rrea_pkg.sv
// Shared types, constants and arithmetic helpers for the rounded rectangle edge antialias unit.
package rrea_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CHAN_BITS      = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL   = 2'd3;

  localparam int SAMP_AXIS  = 4;
  localparam int SAMP_COUNT = SAMP_AXIS * SAMP_AXIS;
  localparam int CNT_BITS   = $clog2(SAMP_COUNT + 1);
  localparam int SUB_SHIFT  = 3;

  localparam logic [CHAN_BITS-1:0] ALPHA_MAX  = 8'hFF;
  localparam logic [CHAN_BITS-1:0] ALPHA_ZERO = 8'h00;
  localparam logic [15:0]          ROUND_HALF = 16'd127;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_FULL,
    KIND_EDGE
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } carry_t;

  function automatic logic [CHAN_BITS-1:0] cov_of(input logic [CNT_BITS-1:0] n);
    logic [12:0] t;
    t = 13'(n) * 13'd255 + 13'(SAMP_COUNT / 2);
    return 8'(t >> $clog2(SAMP_COUNT));
  endfunction

  function automatic logic [CHAN_BITS-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

### hdl/rounded_rect_edge_antialias_unit.sv
// Rounded rectangle edge antialias unit: 4x4 supersampled corner coverage and colour blend.
// Throughput: one transaction per cycle; a stalled output freezes every stage at once.
// The last stage is the output register, so a waiting result never drops or repeats.
// Reset (rst_n low, synchronous) clears all stage valid bits and sets width 1, height 1,
// radius 0 and fill colour 0; configuration writes are always ready.
module rounded_rect_edge_antialias_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rrea_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [rrea_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [COORD_BITS-1:0]                  in_pixel_row,
  input  logic [COORD_BITS-1:0]                  in_pixel_column,
  input  logic [rrea_pkg::CHAN_BITS-1:0]         in_dest_red,
  input  logic [rrea_pkg::CHAN_BITS-1:0]         in_dest_green,
  input  logic [rrea_pkg::CHAN_BITS-1:0]         in_dest_blue,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [rrea_pkg::CHAN_BITS-1:0]         out_red,
  output logic [rrea_pkg::CHAN_BITS-1:0]         out_green,
  output logic [rrea_pkg::CHAN_BITS-1:0]         out_blue,
  output logic                                   out_pixel_changed,
  output logic [rrea_pkg::CHAN_BITS-1:0]         out_edge_alpha
);
  import rrea_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int KW  = CB + SUB_SHIFT;
  localparam int SQW = 2 * CB;
  localparam int TW  = 2 * CB + 2;
  localparam int LW  = 2 * CB + 2 * SUB_SHIFT + 4;
  localparam int NST = 11;

  logic [CB-1:0]            width_r, height_r, radius_r;
  logic [CFG_DATA_BITS-1:0] fill_r;

  logic [NST-1:0] vld_r;
  logic           adv;
  carry_t         c_r [NST-1];

  logic [CB-1:0]  s1_row_r, s1_col_r, s1_rad_r;
  logic           s1_rlo_r, s1_clo_r;
  logic [CB-1:0]  s2_mrow_r, s2_mcol_r, s2_rad_r;
  logic [CB-1:0]  s3_d_r, s3_e_r, s3_rad_r;
  logic [SQW-1:0] s4_d2_r, s4_e2_r, s4_r2_r;
  logic [KW-1:0]  s4_dk_r [SAMP_AXIS];
  logic [KW-1:0]  s4_ek_r [SAMP_AXIS];
  logic [TW-1:0]  s5_t_r;
  logic [KW-1:0]  s5_dk_r [SAMP_AXIS];
  logic [KW-1:0]  s5_ek_r [SAMP_AXIS];
  logic [SAMP_COUNT-1:0] s6_hit_r;
  logic [CHAN_BITS-1:0]  s7_cov_r;
  logic [15:0]           s8_prod_r;
  logic [CHAN_BITS-1:0]  s9_alpha_r;
  logic [15:0]           s10_blend_r [3];
  logic [CHAN_BITS-1:0]  s10_alpha_r;
  logic [CHAN_BITS-1:0]  out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic                  out_changed_r;

  logic [CB-1:0]  half_w, half_h, rad_nxt;
  carry_t         c1_nxt, c2_nxt, c9_nxt;
  logic [CB-1:0]  mrow_nxt, mcol_nxt;
  logic [TW-1:0]  t_nxt;
  logic [SAMP_COUNT-1:0] hit_nxt;
  logic [CHAN_BITS-1:0]  fill_alpha, alpha_nxt;
  logic [CHAN_BITS-1:0]  fill_ch [3];
  logic [CHAN_BITS-1:0]  dest_ch [3];
  logic [CHAN_BITS-1:0]  out_red_nxt, out_green_nxt, out_blue_nxt, out_alpha_nxt;
  logic                  out_changed_nxt;

  assign cfg_ready = 1'b1;
  assign adv       = !(vld_r[NST-1] && out_stall);
  assign in_stall  = !adv;

  assign fill_ch[0] = fill_r[31:24];
  assign fill_ch[1] = fill_r[23:16];
  assign fill_ch[2] = fill_r[15:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CB'(1);
      height_r <= CB'(1);
      radius_r <= '0;
      fill_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[CB-1:0];
        REG_HEIGHT: height_r <= cfg_data[CB-1:0];
        REG_RADIUS: radius_r <= cfg_data[CB-1:0];
        REG_FILL:   fill_r   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // clamp radius, classify against the rectangle
  always_comb begin
    half_w  = width_r >> 1;
    half_h  = height_r >> 1;
    rad_nxt = radius_r;
    if (rad_nxt > half_w) rad_nxt = half_w;
    if (rad_nxt > half_h) rad_nxt = half_h;
    c1_nxt.kind  = (in_pixel_row < height_r && in_pixel_column < width_r) ? KIND_EDGE
                                                                          : KIND_PASS;
    c1_nxt.red   = in_dest_red;
    c1_nxt.green = in_dest_green;
    c1_nxt.blue  = in_dest_blue;
  end

  // mirror into the top-left corner, mark pixels outside the corner squares as fully covered
  always_comb begin
    mrow_nxt = s1_rlo_r ? s1_row_r : height_r - s1_row_r - CB'(1);
    mcol_nxt = s1_clo_r ? s1_col_r : width_r - s1_col_r - CB'(1);
    c2_nxt   = c_r[0];
    if (c_r[0].kind == KIND_EDGE &&
        (s1_rad_r == '0 || mrow_nxt >= s1_rad_r || mcol_nxt >= s1_rad_r)) begin
      c2_nxt.kind = KIND_FULL;
    end
  end

  assign t_nxt = TW'(s4_d2_r) + TW'(s4_e2_r) - TW'(s4_r2_r);

  // sample test in eighth-pixel units, expanded around d = r - mirrored col, e = r - mirrored row
  always_comb begin
    logic [LW-1:0] t_ext;
    logic [LW-1:0] lane;
    t_ext = {{(LW-TW){s5_t_r[TW-1]}}, s5_t_r};
    for (int sy = 0; sy < SAMP_AXIS; sy++) begin
      for (int sx = 0; sx < SAMP_AXIS; sx++) begin
        lane = (t_ext << (2 * SUB_SHIFT))
             - (LW'(s5_dk_r[sx]) << (SUB_SHIFT + 1))
             - (LW'(s5_ek_r[sy]) << (SUB_SHIFT + 1))
             + LW'((2 * sx + 1) * (2 * sx + 1) + (2 * sy + 1) * (2 * sy + 1));
        hit_nxt[sy * SAMP_AXIS + sx] = lane[LW-1] || lane == '0;
      end
    end
  end

  assign fill_alpha = (fill_r[7:0] == ALPHA_ZERO) ? ALPHA_MAX : fill_r[7:0];
  assign alpha_nxt  = div255(s8_prod_r);

  always_comb begin
    c9_nxt = c_r[7];
    if (c_r[7].kind == KIND_EDGE) begin
      if (alpha_nxt == ALPHA_ZERO) begin
        c9_nxt.kind = KIND_PASS;
      end else if (alpha_nxt == ALPHA_MAX) begin
        c9_nxt.kind = KIND_FULL;
      end
    end
  end

  assign dest_ch[0] = c_r[8].red;
  assign dest_ch[1] = c_r[8].green;
  assign dest_ch[2] = c_r[8].blue;

  always_comb begin
    unique case (c_r[9].kind)
      KIND_FULL: begin
        out_red_nxt     = fill_ch[0];
        out_green_nxt   = fill_ch[1];
        out_blue_nxt    = fill_ch[2];
        out_changed_nxt = 1'b1;
        out_alpha_nxt   = ALPHA_MAX;
      end
      KIND_EDGE: begin
        out_red_nxt     = div255(s10_blend_r[0]);
        out_green_nxt   = div255(s10_blend_r[1]);
        out_blue_nxt    = div255(s10_blend_r[2]);
        out_changed_nxt = 1'b1;
        out_alpha_nxt   = s10_alpha_r;
      end
      default: begin
        out_red_nxt     = c_r[9].red;
        out_green_nxt   = c_r[9].green;
        out_blue_nxt    = c_r[9].blue;
        out_changed_nxt = 1'b0;
        out_alpha_nxt   = ALPHA_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r[0]   <= c1_nxt;
      s1_row_r <= in_pixel_row;
      s1_col_r <= in_pixel_column;
      s1_rad_r <= rad_nxt;
      s1_rlo_r <= in_pixel_row < rad_nxt;
      s1_clo_r <= in_pixel_column < rad_nxt;

      c_r[1]    <= c2_nxt;
      s2_mrow_r <= mrow_nxt;
      s2_mcol_r <= mcol_nxt;
      s2_rad_r  <= s1_rad_r;

      c_r[2]   <= c_r[1];
      s3_d_r   <= s2_rad_r - s2_mcol_r;
      s3_e_r   <= s2_rad_r - s2_mrow_r;
      s3_rad_r <= s2_rad_r;

      c_r[3]  <= c_r[2];
      s4_d2_r <= SQW'(s3_d_r) * SQW'(s3_d_r);
      s4_e2_r <= SQW'(s3_e_r) * SQW'(s3_e_r);
      s4_r2_r <= SQW'(s3_rad_r) * SQW'(s3_rad_r);
      for (int k = 0; k < SAMP_AXIS; k++) begin
        s4_dk_r[k] <= KW'(s3_d_r) * KW'(2 * k + 1);
        s4_ek_r[k] <= KW'(s3_e_r) * KW'(2 * k + 1);
      end

      c_r[4]  <= c_r[3];
      s5_t_r  <= t_nxt;
      s5_dk_r <= s4_dk_r;
      s5_ek_r <= s4_ek_r;

      c_r[5]   <= c_r[4];
      s6_hit_r <= hit_nxt;

      c_r[6]   <= c_r[5];
      s7_cov_r <= cov_of(CNT_BITS'($countones(s6_hit_r)));

      c_r[7]    <= c_r[6];
      s8_prod_r <= 16'(fill_alpha) * 16'(s7_cov_r) + ROUND_HALF;

      c_r[8]     <= c9_nxt;
      s9_alpha_r <= alpha_nxt;

      c_r[9]      <= c_r[8];
      s10_alpha_r <= s9_alpha_r;
      for (int ch = 0; ch < 3; ch++) begin
        s10_blend_r[ch] <= 16'(fill_ch[ch]) * 16'(s9_alpha_r)
                         + 16'(dest_ch[ch]) * 16'(ALPHA_MAX - s9_alpha_r);
      end

      out_red_r     <= out_red_nxt;
      out_green_r   <= out_green_nxt;
      out_blue_r    <= out_blue_nxt;
      out_changed_r <= out_changed_nxt;
      out_alpha_r   <= out_alpha_nxt;
    end
  end

  assign out_valid         = vld_r[NST-1];
  assign out_red           = out_red_r;
  assign out_green         = out_green_r;
  assign out_blue          = out_blue_r;
  assign out_pixel_changed = out_changed_r;
  assign out_edge_alpha    = out_alpha_r;

  a_kept_no_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_changed |-> out_edge_alpha == ALPHA_ZERO)
    else $error("kept pixel carries nonzero alpha");

  a_written_has_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_changed |-> out_edge_alpha != ALPHA_ZERO)
    else $error("written pixel carries zero alpha");

  a_full_is_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_alpha == ALPHA_MAX |->
      out_red == fill_r[31:24] && out_green == fill_r[23:16] && out_blue == fill_r[15:8])
    else $error("fully covered pixel differs from fill colour");

endmodule

### dv/rrea_blend_checker.sv
`timescale 1ns / 100ps
// Checker for the rounded rectangle edge antialias unit: tracks registers, predicts and compares.
module rrea_blend_checker #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [rrea_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rrea_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [COORD_BITS-1:0]               in_pixel_row,
  input  logic [COORD_BITS-1:0]               in_pixel_column,
  input  logic [rrea_pkg::CHAN_BITS-1:0]      in_dest_red,
  input  logic [rrea_pkg::CHAN_BITS-1:0]      in_dest_green,
  input  logic [rrea_pkg::CHAN_BITS-1:0]      in_dest_blue,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [rrea_pkg::CHAN_BITS-1:0]      out_red,
  input  logic [rrea_pkg::CHAN_BITS-1:0]      out_green,
  input  logic [rrea_pkg::CHAN_BITS-1:0]      out_blue,
  input  logic                                out_pixel_changed,
  input  logic [rrea_pkg::CHAN_BITS-1:0]      out_edge_alpha,
  output int unsigned                         outstanding,
  output int unsigned                         mismatch_count
);
  import rrea_pkg::*;

  localparam int SUB_STEPS = 2 * SAMP_AXIS;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
    logic                 changed;
    logic [CHAN_BITS-1:0] alpha;
  } shaded_pixel_t;

  logic [COORD_BITS-1:0]    width_q  = 1;
  logic [COORD_BITS-1:0]    height_q = 1;
  logic [COORD_BITS-1:0]    radius_q = 0;
  logic [CFG_DATA_BITS-1:0] fill_q   = 0;

  shaded_pixel_t expected_colours[$];
  shaded_pixel_t want;
  int unsigned   errors = 0;

  assign mismatch_count = errors;

  function automatic int unsigned corner_hits(input logic [COORD_BITS-1:0] col,
                                              input logic [COORD_BITS-1:0] mrow,
                                              input logic [COORD_BITS-1:0] rad);
    longint      span, limit, dx, dy;
    int unsigned hits;
    span  = longint'(rad) * SUB_STEPS;
    limit = span * span;
    hits  = 0;
    for (int sy = 0; sy < SAMP_AXIS; sy++) begin
      dy = span - longint'(mrow) * SUB_STEPS - longint'(2 * sy + 1);
      for (int sx = 0; sx < SAMP_AXIS; sx++) begin
        dx = span - longint'(col) * SUB_STEPS - longint'(2 * sx + 1);
        if (dx * dx + dy * dy <= limit) hits++;
      end
    end
    return hits;
  endfunction

  function automatic logic [CHAN_BITS-1:0] mix_chan(input int unsigned fill,
                                                    input int unsigned dest,
                                                    input int unsigned a);
    return CHAN_BITS'((fill * a + dest * (255 - a)) / 255);
  endfunction

  function automatic shaded_pixel_t shade_pixel(input logic [COORD_BITS-1:0] row,
                                                input logic [COORD_BITS-1:0] col,
                                                input logic [CHAN_BITS-1:0]  dr,
                                                input logic [CHAN_BITS-1:0]  dg,
                                                input logic [CHAN_BITS-1:0]  db);
    logic [CHAN_BITS-1:0]  fr, fg, fb;
    logic [COORD_BITS-1:0] rad, mrow, mcol;
    int unsigned           base, hits, cov, a;
    shaded_pixel_t         res;
    fr   = fill_q[31:24];
    fg   = fill_q[23:16];
    fb   = fill_q[15:8];
    base = (fill_q[7:0] == 0) ? 255 : fill_q[7:0];
    rad  = radius_q;
    if (rad > (width_q >> 1)) rad = width_q >> 1;
    if (rad > (height_q >> 1)) rad = height_q >> 1;
    res = '{dr, dg, db, 1'b0, ALPHA_ZERO};
    if (row < height_q && col < width_q) begin
      mrow = (row < rad) ? row : height_q - 1'b1 - row;
      mcol = (col < rad) ? col : width_q - 1'b1 - col;
      if (rad == 0 || mrow >= rad || mcol >= rad) begin
        res = '{fr, fg, fb, 1'b1, ALPHA_MAX};
      end else begin
        hits = corner_hits(mcol, mrow, rad);
        if (hits != 0) begin
          cov = (hits * 255 + SAMP_COUNT / 2) / SAMP_COUNT;
          a   = (base * cov + 127) / 255;
          if (a >= 255) begin
            res = '{fr, fg, fb, 1'b1, ALPHA_MAX};
          end else if (a != 0) begin
            res = '{mix_chan(fr, dr, a), mix_chan(fg, dg, a),
                    mix_chan(fb, db, a), 1'b1, CHAN_BITS'(a)};
          end
        end
      end
    end
    return res;
  endfunction

  task automatic compare_field(input string what, input logic [CHAN_BITS-1:0] exp_val,
                               input logic [CHAN_BITS-1:0] got);
    if (got !== exp_val) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, what, exp_val, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_q  = 1;
      height_q = 1;
      radius_q = 0;
      fill_q   = 0;
      expected_colours.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:  width_q  = cfg_data[COORD_BITS-1:0];
          REG_HEIGHT: height_q = cfg_data[COORD_BITS-1:0];
          REG_RADIUS: radius_q = cfg_data[COORD_BITS-1:0];
          REG_FILL:   fill_q   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_colours.insert(expected_colours.size(),
                                shade_pixel(in_pixel_row, in_pixel_column,
                                            in_dest_red, in_dest_green, in_dest_blue));
      end
      if (out_valid && !out_stall) begin
        if (expected_colours.size() == 0) begin
          errors++;
          $display("%0t: pixel expected none, got rgb %0d %0d %0d changed %0d alpha %0d",
                   $time, out_red, out_green, out_blue, out_pixel_changed, out_edge_alpha);
        end else begin
          want = expected_colours.pop_front();
          compare_field("red", want.red, out_red);
          compare_field("green", want.green, out_green);
          compare_field("blue", want.blue, out_blue);
          compare_field("pixel_changed", CHAN_BITS'(want.changed),
                        {{(CHAN_BITS-1){1'b0}}, out_pixel_changed});
          compare_field("edge_alpha", want.alpha, out_edge_alpha);
        end
      end
      outstanding <= expected_colours.size();
    end
  end

endmodule

### dv/tb_rounded_rect_edge_antialias_unit.sv
`timescale 1ns / 100ps
// Testbench top for the rounded rectangle edge antialias unit: clock, reset, stimulus and verdict.
module tb_rounded_rect_edge_antialias_unit;
  import rrea_pkg::*;

  localparam int COORD_BITS   = 12;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 90;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_t;

  logic                      clk             = 1'b0;
  logic                      rst_n           = 1'b0;
  logic                      cfg_valid       = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index       = REG_WIDTH;
  logic [CFG_DATA_BITS-1:0]  cfg_data        = '0;
  logic                      in_valid        = 1'b0;
  logic [COORD_BITS-1:0]     in_pixel_row    = '0;
  logic [COORD_BITS-1:0]     in_pixel_column = '0;
  logic [CHAN_BITS-1:0]      in_dest_red     = '0;
  logic [CHAN_BITS-1:0]      in_dest_green   = '0;
  logic [CHAN_BITS-1:0]      in_dest_blue    = '0;
  logic                      out_stall       = 1'b0;

  logic                      cfg_ready;
  logic                      in_stall;
  logic                      out_valid;
  logic [CHAN_BITS-1:0]      out_red;
  logic [CHAN_BITS-1:0]      out_green;
  logic [CHAN_BITS-1:0]      out_blue;
  logic                      out_pixel_changed;
  logic [CHAN_BITS-1:0]      out_edge_alpha;

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned cycle_count = 0;
  int          burst_left  = 0;

  logic [COORD_BITS-1:0] rect_w   = 1;
  logic [COORD_BITS-1:0] rect_h   = 1;
  logic [COORD_BITS-1:0] rect_rad = 0;

  logic        hold_off_req = 1'b0;
  logic        hold_taken   = 1'b0;
  int          hold_left    = 0;
  int          stall_left   = 0;
  stall_mode_t stall_mode   = STALL_NONE;

  rounded_rect_edge_antialias_unit #(
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_row     (in_pixel_row),
    .in_pixel_column  (in_pixel_column),
    .in_dest_red      (in_dest_red),
    .in_dest_green    (in_dest_green),
    .in_dest_blue     (in_dest_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_pixel_changed(out_pixel_changed),
    .out_edge_alpha   (out_edge_alpha)
  );

  rrea_blend_checker #(
    .COORD_BITS(COORD_BITS)
  ) blend_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_row     (in_pixel_row),
    .in_pixel_column  (in_pixel_column),
    .in_dest_red      (in_dest_red),
    .in_dest_green    (in_dest_green),
    .in_dest_blue     (in_dest_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_pixel_changed(out_pixel_changed),
    .out_edge_alpha   (out_edge_alpha),
    .outstanding      (outstanding),
    .mismatch_count   (mismatches)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      stall_mode <= STALL_NONE;
    end else if (hold_off_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 2));
        stall_left <= $urandom_range(4, 48);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_rect(input logic [COORD_BITS-1:0] w, input logic [COORD_BITS-1:0] h,
                              input logic [COORD_BITS-1:0] rad, input logic [31:0] fill);
    wait_idle();
    rect_w   = w;
    rect_h   = h;
    rect_rad = rad;
    write_reg(REG_WIDTH, {20'($urandom), w});
    write_reg(REG_HEIGHT, {20'($urandom), h});
    write_reg(REG_RADIUS, {20'($urandom), rad});
    write_reg(REG_FILL, fill);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [COORD_BITS-1:0] row, input logic [COORD_BITS-1:0] col,
                            input logic [CHAN_BITS-1:0] r, input logic [CHAN_BITS-1:0] g,
                            input logic [CHAN_BITS-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_pixel_row    <= row;
    in_pixel_column <= col;
    in_dest_red     <= r;
    in_dest_green   <= g;
    in_dest_blue    <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord(input logic [COORD_BITS-1:0] size,
                                                       input logic [COORD_BITS-1:0] rad);
    int span;
    if (size == 0) return COORD_BITS'($urandom);
    span = ((rad > (size >> 1)) ? (size >> 1) : rad) + 1;
    if (span > size - 1) span = size - 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return COORD_BITS'($urandom_range(0, span));
      4, 5, 6:    return size - 1'b1 - COORD_BITS'($urandom_range(0, span));
      7, 8:       return COORD_BITS'($urandom_range(0, size - 1));
      default:    return COORD_BITS'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int count, input bit long_hold, input bit mid_drain);
    for (int k = 0; k < count; k++) begin
      if (long_hold && k == count / 4) hold_off_req <= 1'b1;
      if (mid_drain && k == count / 2) wait_idle();
      send_pixel(pick_coord(rect_h, rect_rad), pick_coord(rect_w, rect_rad),
                 CHAN_BITS'($urandom), CHAN_BITS'($urandom), CHAN_BITS'($urandom));
    end
  endtask

  initial begin
    logic [31:0] fill_word;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_pixel(12'd0, 12'd0, 8'd255, 8'd255, 8'd255);
    send_pixel(12'd0, 12'd1, 8'd12, 8'd34, 8'd56);

    program_rect(12'd0, 12'd5, 12'd3, 32'h11223344);
    send_pixel(12'd0, 12'd0, 8'd1, 8'd2, 8'd3);

    program_rect(12'd16, 12'd16, 12'd8, 32'hFF804000);
    send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(12'd0, 12'd15, 8'd255, 8'd255, 8'd255);
    send_pixel(12'd15, 12'd0, 8'd0, 8'd255, 8'd0);
    send_pixel(12'd15, 12'd15, 8'd255, 8'd0, 8'd255);
    send_pixel(12'd7, 12'd7, 8'd10, 8'd20, 8'd30);
    send_pixel(12'd2, 12'd1, 8'd200, 8'd100, 8'd50);
    send_pixel(12'd8, 12'd8, 8'd0, 8'd0, 8'd0);
    send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
    send_pixel(12'd0, 12'd8, 8'd1, 8'd1, 8'd1);

    program_rect(12'd4095, 12'd4095, 12'd4095, 32'h10203001);
    send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(12'd4094, 12'd4094, 8'd255, 8'd255, 8'd255);
    send_pixel(12'd2047, 12'd0, 8'd90, 8'd80, 8'd70);
    send_pixel(12'd1000, 12'd1000, 8'd250, 8'd5, 8'd128);
    send_pixel(12'd4095, 12'd0, 8'd33, 8'd44, 8'd55);

    program_rect(12'd7, 12'd9, 12'd100, 32'hC0C0C080);
    send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(12'd0, 12'd1, 8'd255, 8'd255, 8'd255);
    send_pixel(12'd1, 12'd0, 8'd17, 8'd170, 8'd85);
    send_pixel(12'd8, 12'd6, 8'd0, 8'd255, 8'd128);
    send_pixel(12'd4, 12'd3, 8'd9, 8'd9, 8'd9);

    for (int p = 0; p < 8; p++) begin
      fill_word = 32'($urandom);
      case ($urandom_range(0, 2))
        0:       fill_word[7:0] = ALPHA_ZERO;
        1:       fill_word[7:0] = ALPHA_MAX;
        default: ;
      endcase
      case (p)
        0:       program_rect(12'd4095, 12'd4095, 12'd4095, {fill_word[31:8], ALPHA_MAX});
        1:       program_rect(12'd1, 12'd4095, COORD_BITS'($urandom), fill_word);
        2:       program_rect(12'd2, 12'd2, 12'd1, fill_word);
        default: program_rect(COORD_BITS'($urandom_range(1, 64)),
                              COORD_BITS'($urandom_range(1, 64)),
                              COORD_BITS'($urandom_range(0, 40)), fill_word);
      endcase
      random_phase(50, p == 3, p == 4);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
